// ----- rtl/ddo_pkg.sv -----
`default_nettype none
package ddo_pkg;

   // rotation count of the cordic
   localparam int CORDIC_STEPS = 24;
   localparam int CNT_W = $clog2(CORDIC_STEPS);

   // register indexes of the csr port
   localparam logic [1:0] REG_DIST_PER_STEP = 2'd0;
   localparam logic [1:0] REG_INV_TRACK_WIDTH = 2'd1;

   // reset values of the registers
   localparam logic [31:0] DIST_RESET = 32'd1152963;
   localparam logic [31:0] ITW_RESET = 32'd17179869;

   // angle constants, 2^-28 rad, and the cordic gain in q30
   localparam logic signed [31:0] PI_Q = 32'sd843314857;
   localparam logic signed [31:0] TWO_PI_Q = 32'sd1686629713;
   localparam logic signed [31:0] HALF_PI_Q = 32'sd421657428;
   localparam logic signed [31:0] K_Q30 = 32'sd652032874;

   // arctangent of 2^-i, 2^-28 rad, padded with zeros
   localparam logic [27:0] ATAN_TAB [32] = '{
      28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290, 28'd16755422,
      28'd8385879, 28'd4193963, 28'd2097109, 28'd1048571, 28'd524287,
      28'd262144, 28'd131072, 28'd65536, 28'd32768, 28'd16384,
      28'd8192, 28'd4096, 28'd2048, 28'd1024, 28'd512,
      28'd256, 28'd128, 28'd64, 28'd32, 28'd16,
      28'd8, 28'd4, 28'd2, 28'd1, 28'd0, 28'd0, 28'd0};

   // sequencer states
   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_MUL  = 10'b0000000010,
      S_ACC  = 10'b0000000100,
      S_PREP = 10'b0000001000,
      S_HEAD = 10'b0000010000,
      S_WRAP = 10'b0000100000,
      S_ROT  = 10'b0001000000,
      S_TRIG = 10'b0010000000,
      S_YUPD = 10'b0100000000,
      S_OUT  = 10'b1000000000
   } state_type;

   // multiply jobs of the shared multiplier
   typedef enum logic [2:0] {
      OP_LEFT  = 3'd0,
      OP_RIGHT = 3'd1,
      OP_TH_LO = 3'd2,
      OP_TH_HI = 3'd3,
      OP_X_LO  = 3'd4,
      OP_X_HI  = 3'd5,
      OP_Y_LO  = 3'd6,
      OP_Y_HI  = 3'd7
   } op_type;

endpackage
`default_nettype wire

// ----- rtl/ddo_if.sv -----
`default_nettype none

// update or set-pose request channel
interface ddo_req_if;
   logic                valid;
   logic                ready;
   logic                req_type;
   logic signed [31:0]  left_count;
   logic signed [31:0]  right_count;
   logic signed [47:0]  set_x;
   logic signed [47:0]  set_y;
   logic signed [30:0]  set_heading;
   modport source (output valid, req_type, left_count, right_count, set_x, set_y,
                   set_heading, input ready);
   modport sink (input valid, req_type, left_count, right_count, set_x, set_y,
                 set_heading, output ready);
endinterface

// pose response channel
interface ddo_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [47:0]  pos_x;
   logic signed [47:0]  pos_y;
   logic signed [30:0]  heading;
   logic                moved;
   modport source (output valid, pos_x, pos_y, heading, moved, input ready);
   modport sink (input valid, pos_x, pos_y, heading, moved, output ready);
endinterface

// register write channel
interface ddo_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/differential_drive_odometry_unit.sv -----
`default_nettype none
// Dead-reckoning odometry for a differential drive. A request either loads the
// pose (x, y in 2^-16 mm, heading in 2^-28 rad) or brings absolute left and right
// step positions; when either changed, the step deltas become wheel travel, the
// heading turns by the travel difference times the inverse track width, wraps
// once into +-pi, and x and y move by the mean travel times cos and sin of the
// new heading. Every request returns one response with the pose. A moving update
// uses one shared 32x32 multiplier run for eight partial products and one cordic
// stage run once per rotation. The request side is not ready while an update is in
// work. Registers are written through the csr channel, which is always ready; the
// user must write them only while the block is idle, as the block itself does not
// enforce it.
module differential_drive_odometry_unit
   import ddo_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   ddo_req_if.sink     req_chan,
   ddo_rsp_if.source   rsp_chan,
   ddo_csr_if.sink     csr_chan
);

   state_type state_ff;
   op_type    op_ff;

   logic [31:0]        dist_ff, itw_ff;
   logic signed [47:0] x_ff, y_ff;
   logic signed [30:0] hd_ff;
   logic [31:0]        last_l_ff, last_r_ff;
   logic signed [31:0] dl_ff, dr_ff;
   logic signed [63:0] sl_ff, sr_ff;
   logic [63:0]        a_ff, dsm_ff;
   logic               dd_neg_ff, ds_neg_ff;
   logic [63:0]        prod_ff;
   logic [95:0]        acc_ff;
   logic signed [31:0] hraw_ff;
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               flip_ff;
   logic [31:0]        cosm_ff, sinm_ff;
   logic               cos_neg_ff, sin_neg_ff;
   logic               moved_ff;
   logic               rsp_valid_ff;
   logic signed [47:0] rsp_x_ff, rsp_y_ff;
   logic signed [30:0] rsp_h_ff;
   logic               rsp_moved_ff;

   logic        req_fire;
   logic [31:0] dl_new, dr_new;
   logic [31:0] dl_mag, dr_mag;
   logic [31:0] mul_a, mul_b;
   logic [95:0] pp_shift, acc_base;
   logic signed [64:0] diff, ssum;
   logic signed [63:0] ds;
   logic [96:0] th_round;
   logic [68:0] m0;
   logic [30:0] m_cap;
   logic signed [31:0] m_signed, h1, h2;
   logic signed [31:0] cdx, cdy, catan;
   logic signed [31:0] cos_v, sin_v;
   logic [95:0] x_round, y_round;
   logic [47:0] x_term, y_term;
   logic        rsp_free;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // step deltas, wrapped to 32 bits
   assign dl_new = req_chan.left_count - last_l_ff;
   assign dr_new = req_chan.right_count - last_r_ff;
   assign dl_mag = dl_ff[31] ? 32'(-dl_ff) : dl_ff;
   assign dr_mag = dr_ff[31] ? 32'(-dr_ff) : dr_ff;

   // operand selection of the shared multiplier
   always_comb begin
      unique case (op_ff)
         OP_LEFT:  begin mul_a = dl_mag;          mul_b = dist_ff; end
         OP_RIGHT: begin mul_a = dr_mag;          mul_b = dist_ff; end
         OP_TH_LO: begin mul_a = a_ff[31:0];      mul_b = itw_ff;  end
         OP_TH_HI: begin mul_a = a_ff[63:32];     mul_b = itw_ff;  end
         OP_X_LO:  begin mul_a = dsm_ff[31:0];    mul_b = cosm_ff; end
         OP_X_HI:  begin mul_a = dsm_ff[63:32];   mul_b = cosm_ff; end
         OP_Y_LO:  begin mul_a = dsm_ff[31:0];    mul_b = sinm_ff; end
         OP_Y_HI:  begin mul_a = dsm_ff[63:32];   mul_b = sinm_ff; end
         default:  begin mul_a = dl_mag;          mul_b = dist_ff; end
      endcase
   end

   // partial product accumulation; odd jobs, among them the upper halves, add shifted up
   assign pp_shift = op_ff[0] ? {prod_ff, 32'd0} : {32'd0, prod_ff};
   assign acc_base = op_ff[0] ? acc_ff : 96'd0;

   // travel difference and mean travel
   assign diff = {sl_ff[63], sl_ff} - {sr_ff[63], sr_ff};
   assign ssum = {sl_ff[63], sl_ff} + {sr_ff[63], sr_ff};
   assign ds = ssum[64:1];

   // heading change, rounded and capped
   assign th_round = {1'b0, acc_ff} + 97'(1) * (97'd1 << 27);
   assign m0 = th_round[96:28];
   assign m_cap = (m0 > 69'(1 << 30)) ? 31'(1 << 30) : m0[30:0];
   assign m_signed = dd_neg_ff ? -$signed({1'b0, m_cap}) : $signed({1'b0, m_cap});

   // single wrap into +-pi
   assign h1 = (hraw_ff > PI_Q) ? hraw_ff - TWO_PI_Q : hraw_ff;
   assign h2 = (h1 < -PI_Q) ? h1 + TWO_PI_Q : h1;

   // one cordic rotation
   assign cdx = cy_ff >>> cnt_ff;
   assign cdy = cx_ff >>> cnt_ff;
   assign catan = $signed({4'd0, ATAN_TAB[5'(cnt_ff)]});

   assign cos_v = flip_ff ? -cx_ff : cx_ff;
   assign sin_v = flip_ff ? -cy_ff : cy_ff;

   // position terms rounded half away from zero
   assign x_round = acc_ff + (96'd1 << 37);
   assign y_round = acc_ff + (96'd1 << 37);
   assign x_term = x_round[85:38];
   assign y_term = y_round[85:38];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= DIST_RESET;
         itw_ff  <= ITW_RESET;
      end else if (csr_chan.valid) begin
         if (csr_chan.index == REG_DIST_PER_STEP) dist_ff <= csr_chan.data;
         if (csr_chan.index == REG_INV_TRACK_WIDTH) itw_ff <= csr_chan.data;
      end
   end

   // sequencer and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_LEFT;
         x_ff         <= '0;
         y_ff         <= '0;
         hd_ff        <= '0;
         last_l_ff    <= '0;
         last_r_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // response taken, unless a new one is loaded below
         if (rsp_valid_ff && rsp_chan.ready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (req_chan.req_type) begin
                     x_ff     <= req_chan.set_x;
                     y_ff     <= req_chan.set_y;
                     hd_ff    <= req_chan.set_heading;
                     moved_ff <= 1'b1;
                     state_ff <= S_OUT;
                  end else if (dl_new != 32'd0 || dr_new != 32'd0) begin
                     last_l_ff <= req_chan.left_count;
                     last_r_ff <= req_chan.right_count;
                     dl_ff     <= dl_new;
                     dr_ff     <= dr_new;
                     op_ff     <= OP_LEFT;
                     moved_ff  <= 1'b1;
                     state_ff  <= S_MUL;
                  end else begin
                     moved_ff <= 1'b0;
                     state_ff <= S_OUT;
                  end
               end
            end
            S_MUL: begin
               prod_ff <= 64'(mul_a) * 64'(mul_b);
               // x moves once its product is complete
               if (op_ff == OP_Y_LO)
                  x_ff <= x_ff + ((ds_neg_ff ^ cos_neg_ff) ? -x_term : x_term);
               state_ff <= S_ACC;
            end
            S_ACC: begin
               acc_ff <= acc_base + pp_shift;
               unique case (op_ff)
                  OP_LEFT: begin
                     sl_ff    <= dl_ff[31] ? -$signed(prod_ff) : $signed(prod_ff);
                     op_ff    <= OP_RIGHT;
                     state_ff <= S_MUL;
                  end
                  OP_RIGHT: begin
                     sr_ff    <= dr_ff[31] ? -$signed(prod_ff) : $signed(prod_ff);
                     state_ff <= S_PREP;
                  end
                  OP_TH_LO: begin op_ff <= OP_TH_HI; state_ff <= S_MUL; end
                  OP_TH_HI: state_ff <= S_HEAD;
                  OP_X_LO:  begin op_ff <= OP_X_HI; state_ff <= S_MUL; end
                  OP_X_HI:  begin op_ff <= OP_Y_LO; state_ff <= S_MUL; end
                  OP_Y_LO:  begin op_ff <= OP_Y_HI; state_ff <= S_MUL; end
                  OP_Y_HI:  state_ff <= S_YUPD;
                  default:  state_ff <= S_IDLE;
               endcase
            end
            S_PREP: begin
               a_ff      <= diff[64] ? 64'(-diff) : diff[63:0];
               dd_neg_ff <= diff[64];
               dsm_ff    <= ds[63] ? 64'(-ds) : ds;
               ds_neg_ff <= ds[63];
               op_ff     <= OP_TH_LO;
               state_ff  <= S_MUL;
            end
            S_HEAD: begin
               hraw_ff  <= 32'($signed(hd_ff)) + m_signed;
               state_ff <= S_WRAP;
            end
            S_WRAP: begin
               hd_ff  <= h2[30:0];
               cx_ff  <= K_Q30;
               cy_ff  <= '0;
               cnt_ff <= '0;
               if (h2 > HALF_PI_Q) begin
                  cz_ff   <= h2 - PI_Q;
                  flip_ff <= 1'b1;
               end else if (h2 < -HALF_PI_Q) begin
                  cz_ff   <= h2 + PI_Q;
                  flip_ff <= 1'b1;
               end else begin
                  cz_ff   <= h2;
                  flip_ff <= 1'b0;
               end
               state_ff <= S_ROT;
            end
            S_ROT: begin
               if (!cz_ff[31]) begin
                  cx_ff <= cx_ff - cdx;
                  cy_ff <= cy_ff + cdy;
                  cz_ff <= cz_ff - catan;
               end else begin
                  cx_ff <= cx_ff + cdx;
                  cy_ff <= cy_ff - cdy;
                  cz_ff <= cz_ff + catan;
               end
               if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) state_ff <= S_TRIG;
               else cnt_ff <= cnt_ff + 1'b1;
            end
            S_TRIG: begin
               cos_neg_ff <= cos_v[31];
               cosm_ff    <= cos_v[31] ? 32'(-cos_v) : cos_v;
               sin_neg_ff <= sin_v[31];
               sinm_ff    <= sin_v[31] ? 32'(-sin_v) : sin_v;
               op_ff      <= OP_X_LO;
               state_ff   <= S_MUL;
            end
            S_YUPD: begin
               y_ff     <= y_ff + ((ds_neg_ff ^ sin_neg_ff) ? -y_term : y_term);
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_x_ff     <= x_ff;
                  rsp_y_ff     <= y_ff;
                  rsp_h_ff     <= hd_ff;
                  rsp_moved_ff <= moved_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // response outputs
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.pos_x   = rsp_x_ff;
   assign rsp_chan.pos_y   = rsp_y_ff;
   assign rsp_chan.heading = rsp_h_ff;
   assign rsp_chan.moved   = rsp_moved_ff;

endmodule
`default_nettype wire

// ----- rtl/ddo_checker.sv -----
`default_nettype none
module ddo_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [47:0] rsp_pos_x,
   input wire [30:0] rsp_heading
);

   // block comes out of reset idle with no response pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

   // an accepted request leaves the block busy in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a stalled response stays valid and holds its x and heading
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x)
         && $stable(rsp_heading))
      else $error("stalled response changed");

endmodule

bind differential_drive_odometry_unit ddo_checker u_ddo_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_pos_x   (rsp_chan.pos_x),
   .rsp_heading (rsp_chan.heading)
);
`default_nettype wire

// ----- tb/tb_ifaces.sv -----
package tb_pose_pkg;
   // expected pose of one response transaction
   typedef struct packed {
      logic [47:0] pos_x;
      logic [47:0] pos_y;
      logic [30:0] heading;
      logic        moved;
   } pose_type;
endpackage

// ----- tb/tb_checker.sv -----
module tb_checker
   import ddo_pkg::*;
   import tb_pose_pkg::*;
(
   input  wire  clock,
   input  wire  reset,
   ddo_req_if   req_mon,
   ddo_rsp_if   rsp_mon,
   ddo_csr_if   csr_mon,
   output int   fail_count,
   output int   pending_poses
);

   // predictor state
   logic [31:0] dist_reg;
   logic [31:0] itw_reg;
   logic [47:0] x_st;
   logic [47:0] y_st;
   logic signed [63:0] head_st;
   logic [31:0] last_l;
   logic [31:0] last_r;
   pose_type expected_poses[$];

   localparam longint ATAN_V [30] = '{
      210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
      4193963, 2097109, 1048571, 524287, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048,
      1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};

   // round(a*b / 2^k) half up, saturating
   function automatic logic [63:0] mul_round(logic [63:0] a, logic [31:0] b, int k);
      logic [127:0] p;
      p = a * b + (128'd1 << (k - 1));
      p = p >> k;
      if (p[127:64] != 0) return 64'hFFFF_FFFF_FFFF_FFFF;
      return p[63:0];
   endfunction

   function automatic logic [63:0] mag64(longint v);
      return v < 0 ? -v : v;
   endfunction

   // signed ds*c / 2^38 rounded half away from zero
   function automatic logic [63:0] pos_term(longint ds, longint c);
      logic [63:0] m;
      m = mul_round(mag64(ds), 32'(mag64(c)), 38);
      return ((ds < 0) != (c < 0)) ? -m : m;
   endfunction

   // cosine and sine of angle, q30
   task automatic rotate(input longint ang, output longint cs, output longint sn);
      longint cx, cy, z, dx, dy;
      bit flip;
      cx = K_Q30;
      cy = 0;
      flip = 0;
      if (ang > HALF_PI_Q) begin
         ang -= PI_Q;
         flip = 1;
      end else if (ang < -HALF_PI_Q) begin
         ang += PI_Q;
         flip = 1;
      end
      z = ang;
      for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (z >= 0) begin
            cx -= dx; cy += dy; z -= ATAN_V[i];
         end else begin
            cx += dx; cy -= dy; z += ATAN_V[i];
         end
      end
      cs = flip ? -cx : cx;
      sn = flip ? -cy : cy;
   endtask

   // pose after one request
   task automatic advance_pose(input logic kind, input logic [31:0] cl, input logic [31:0] cr,
                               input logic [47:0] sx, input logic [47:0] sy,
                               input logic [30:0] sh, output pose_type res);
      longint dl, dr, sl, sr, ds, dd, h, cs, sn;
      logic [63:0] m;
      logic mv;
      mv = 0;
      if (kind) begin
         x_st = sx;
         y_st = sy;
         head_st = longint'($signed(sh));
         mv = 1;
      end else begin
         dl = longint'($signed(32'(cl - last_l)));
         dr = longint'($signed(32'(cr - last_r)));
         if (dl != 0 || dr != 0) begin
            last_l = cl;
            last_r = cr;
            sl = dl * longint'({32'd0, dist_reg});
            sr = dr * longint'({32'd0, dist_reg});
            ds = (sl >>> 1) + (sr >>> 1) + longint'(sl & sr & 1);
            dd = dl - dr;
            m = mul_round(mag64(dd) * {32'd0, dist_reg}, itw_reg, 28);
            if (m > (64'd1 << 30)) m = 64'd1 << 30;
            h = head_st + (dd < 0 ? -longint'(m) : longint'(m));
            if (h > PI_Q) h -= TWO_PI_Q;
            if (h < -PI_Q) h += TWO_PI_Q;
            head_st = h;
            rotate(h, cs, sn);
            x_st = x_st + 48'(pos_term(ds, cs));
            y_st = y_st + 48'(pos_term(ds, sn));
            mv = 1;
         end
      end
      res.pos_x = x_st;
      res.pos_y = y_st;
      res.heading = 31'(head_st);
      res.moved = mv;
   endtask

   // track transactions on all channels
   always @(posedge clock) begin
      pose_type want;
      if (reset) begin
         dist_reg <= DIST_RESET;
         itw_reg <= ITW_RESET;
         x_st = 0;
         y_st = 0;
         head_st = 0;
         last_l = 0;
         last_r = 0;
         fail_count <= 0;
         expected_poses.delete();
         pending_poses <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == REG_DIST_PER_STEP) dist_reg <= csr_mon.data;
            else if (csr_mon.index == REG_INV_TRACK_WIDTH) itw_reg <= csr_mon.data;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_poses.size() == 0) begin
               $display("%0t unexpected pose x=%h y=%h h=%h", $time, rsp_mon.pos_x,
                        rsp_mon.pos_y, rsp_mon.heading);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_poses.pop_front();
               if (want.pos_x !== rsp_mon.pos_x || want.pos_y !== rsp_mon.pos_y ||
                   want.heading !== rsp_mon.heading || want.moved !== rsp_mon.moved) begin
                  $display("%0t pose mismatch exp x=%h y=%h h=%h m=%b act x=%h y=%h h=%h m=%b",
                           $time, want.pos_x, want.pos_y, want.heading, want.moved,
                           rsp_mon.pos_x, rsp_mon.pos_y, rsp_mon.heading, rsp_mon.moved);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            advance_pose(req_mon.req_type, req_mon.left_count, req_mon.right_count,
                         req_mon.set_x, req_mon.set_y, req_mon.set_heading, want);
            expected_poses.push_back(want);
         end
         pending_poses <= expected_poses.size();
      end
   end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
   import ddo_pkg::*;

   logic clock = 0;
   logic reset = 1;
   int   fail_count;
   int   pending_poses;
   int   cycle_count = 0;
   bit   long_hold = 0;
   bit   calm_phase = 0;
   int   sent = 0;
   logic [31:0] pos_l = 0;
   logic [31:0] pos_r = 0;

   ddo_req_if req_chan();
   ddo_rsp_if rsp_chan();
   ddo_csr_if csr_chan();

   differential_drive_odometry_unit dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink));

   tb_checker chk (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .csr_mon(csr_chan), .fail_count(fail_count), .pending_poses(pending_poses));

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver back-pressure in bursts
   initial begin
      int n;
      rsp_chan.ready <= 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_chan.ready <= 0;
         end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 0;
            n = $urandom_range(1, 19);
            repeat (n - 1) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1;
         end
      end
   end

   // one request transaction
   task automatic send_req(input logic kind, input logic [31:0] cl, input logic [31:0] cr,
                           input logic [47:0] sx, input logic [47:0] sy,
                           input logic [30:0] sh);
      req_chan.valid <= 1;
      req_chan.req_type <= kind;
      req_chan.left_count <= cl;
      req_chan.right_count <= cr;
      req_chan.set_x <= sx;
      req_chan.set_y <= sy;
      req_chan.set_heading <= sh;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent++;
      if (!calm_phase && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic step_move(input int dl, input int dr);
      pos_l = pos_l + dl;
      pos_r = pos_r + dr;
      send_req(1'b0, pos_l, pos_r, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
               31'($urandom));
   endtask

   task automatic set_pose(input logic [47:0] sx, input logic [47:0] sy, input logic [30:0] sh);
      send_req(1'b1, $urandom, $urandom, sx, sy, sh);
   endtask

   // wait until every expected response has come
   task automatic drain;
      req_chan.valid <= 0;
      @(posedge clock);
      while (pending_poses != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_chan.valid <= 1;
      csr_chan.index <= idx;
      csr_chan.data <= val;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 0;
   endtask

   function automatic int small_delta();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return $urandom;
         2: return -$urandom_range(0, 5000);
         default: return $urandom_range(0, 400) - 200;
      endcase
   endfunction

   function automatic logic [30:0] rand_heading();
      if ($urandom_range(0, 3) == 0) return 31'($urandom);
      return 31'($signed($urandom_range(0, 2 * PI_Q)) - PI_Q);
   endfunction

   initial begin
      logic [31:0] dps;
      logic [31:0] itw;
      req_chan.valid <= 0;
      req_chan.req_type <= 0;
      req_chan.left_count <= 0;
      req_chan.right_count <= 0;
      req_chan.set_x <= 0;
      req_chan.set_y <= 0;
      req_chan.set_heading <= 0;
      csr_chan.valid <= 0;
      csr_chan.index <= REG_DIST_PER_STEP;
      csr_chan.data <= 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset registers, extremes and special cases
      step_move(0, 0);
      step_move(100, 100);
      step_move(50, 0);
      step_move(0, -70);
      step_move(0, 0);
      set_pose(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 31'(PI_Q));
      step_move(10, -10);
      set_pose(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 31'h4000_0000);
      step_move(1, 1);
      set_pose(0, 0, 31'h3FFF_FFFF);
      step_move(-3, 2);
      set_pose(0, 0, -31'(PI_Q));
      step_move(32'h7FFF_FFFF, 32'h8000_0000);
      step_move(32'h8000_0000, 32'h7FFF_FFFF);
      step_move(-5, -5);
      drain();
      write_reg(REG_DIST_PER_STEP, 32'hFFFF_FFFF);
      write_reg(REG_INV_TRACK_WIDTH, 32'hFFFF_FFFF);
      step_move(32'h7FFF_FFFF, 32'h8000_0001);
      step_move(1, 0);
      step_move(-1, 1);
      drain();
      write_reg(REG_DIST_PER_STEP, 0);
      write_reg(REG_INV_TRACK_WIDTH, 0);
      step_move(20, 30);
      drain();
      write_reg(REG_DIST_PER_STEP, 1);
      write_reg(REG_INV_TRACK_WIDTH, 1);
      step_move(7, 9);
      drain();

      // random phases with different register settings
      for (int ph = 0; ph < 13; ph++) begin
         case (ph % 4)
            0: begin dps = DIST_RESET; itw = ITW_RESET; end
            1: begin dps = $urandom; itw = $urandom; end
            2: begin dps = $urandom_range(1, 1 << 24); itw = $urandom_range(1, 1 << 28); end
            default: begin dps = 32'hFFFF_FFFF; itw = 1; end
         endcase
         write_reg(REG_DIST_PER_STEP, dps);
         write_reg(REG_INV_TRACK_WIDTH, itw);
         if (ph == 12) calm_phase = 1;
         for (int k = 0; k < 150; k++) begin
            if (ph == 3 && k == 20) begin
               // long receiver hold-off while requests keep coming
               fork
                  begin
                     long_hold = 1;
                     repeat (400) @(posedge clock);
                     long_hold = 0;
                  end
               join_none
            end
            if ($urandom_range(0, 11) == 0) set_pose(48'({$urandom, $urandom}),
                                                   48'({$urandom, $urandom}),
                                                   rand_heading());
            else step_move(small_delta(), small_delta());
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
